// File: sv/knr_pkg.sv
// shared types, constants and codes of the nearest-records selector
`default_nettype none
package knr_pkg;

	// query slots and kept neighbours
	localparam int SLOTS = 6;
	localparam int KEEP  = 15;

	localparam int QIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(KEEP + 1);

	localparam int DIST_W  = 12;
	localparam int RNUM_W  = 10;
	localparam int LABEL_W = 4;
	localparam int VAL_W   = 8;

	localparam logic [DIST_W-1:0] DIST_MAX  = '1;
	localparam logic [RNUM_W-1:0] COUNT_MAX = '1;

	// command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	localparam logic [1:0] OP_QUERY  = 2'd0;
	localparam logic [1:0] OP_RECORD = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam logic KIND_ENTRY  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [2:0]         slot_index;
		logic [VAL_W-1:0]   luck_value;
		logic [VAL_W-1:0]   hp_value;
		logic [LABEL_W-1:0] record_label;
		logic               end_of_record;
	} req_t;

	typedef struct packed {
		logic               item_kind;
		logic [LABEL_W-1:0] label_out;
		logic [DIST_W-1:0]  distance;
		logic [RNUM_W-1:0]  record_number;
		logic               found;
		logic               last;
	} res_t;

	typedef enum logic {
		CMD_RECORD = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_kind_t;

	// one finished record or one finish marker
	typedef struct packed {
		cmd_kind_t          kind;
		logic [DIST_W-1:0]  rec_dist;
		logic [LABEL_W-1:0] label;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_RUN    = 2'd0,
		ST_DRAIN  = 2'd1,
		ST_REPORT = 2'd2
	} back_st_t;

endpackage
`default_nettype wire

// File: sv/l1_nearest_records_top_k_core.sv
// top level of the nearest-records selector (k nearest by l1 distance)
//
// requests come in on a queue-like port: req is taken at a clock edge with push
// high and full low. opcode 0 loads one query slot, opcode 1 adds one slot element
// of a stored record (end_of_record closes it), opcode 2 asks for the results.
// results leave on a queue-like port: res is valid while empty is low and is
// taken at an edge with pop high.
// one request is accepted per cycle while full is low; the front part works each
// element in the cycle it arrives and hands a finished record or a finish to a
// two-entry command queue. the back part inserts one record a cycle into the
// sorted kept list while it is not draining a finish. in the back a finish is
// taken from the queue, then each kept entry leaves, nearest first, then the
// best-record report marked last.
// when pop stays low while results are due, the result register holds, the back
// part stops, the command queue fills and full rises; nothing is dropped.
// reset clears the query to zero and empties the kept list and the best record.
`default_nettype none
module l1_nearest_records_top_k_core
	import knr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire req_t req,
	output logic      empty,
	input  wire logic pop,
	output res_t      res
);

	// front to queue
	logic cmd_push;
	cmd_t cmd_in;

	// queue to back
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd_out;
	logic q_full;

	logic res_valid;
	logic req_fire;
	logic res_take;

	// a request is taken only while the command queue has room
	assign full     = q_full;
	assign req_fire = push && !q_full;

	assign empty    = !res_valid;
	assign res_take = pop && res_valid;

	knr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_fire (req_fire),
		.req      (req),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	knr_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_data  (cmd_in),
		.rd_en    (cmd_pop),
		.rd_data  (cmd_out),
		.nonempty (cmd_valid),
		.is_full  (q_full)
	);

	// back part owns the kept list and the result register
	knr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

endmodule
`default_nettype wire

// File: sv/knr_front.sv
// front part: query store, per-element distance accumulation, command issue
`default_nettype none
module knr_front
	import knr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_fire,
	input  wire req_t req,
	output logic      cmd_push,
	output cmd_t      cmd
);

	logic [VAL_W-1:0]  query_luck_q [SLOTS];
	logic [VAL_W-1:0]  query_hp_q   [SLOTS];
	logic [DIST_W-1:0] partial_sum_q;

	logic              slot_ok;
	logic [QIDX_W-1:0] qidx;
	logic [VAL_W-1:0]  ql, qh;
	logic [VAL_W-1:0]  dl, dh;
	logic [DIST_W:0]   sum_wide;
	logic [DIST_W-1:0] sum_sat;
	logic              is_rec, is_fin;

	assign slot_ok = int'(req.slot_index) < SLOTS;
	assign qidx    = req.slot_index[QIDX_W-1:0];
	assign ql      = query_luck_q[qidx];
	assign qh      = query_hp_q[qidx];
	assign dl      = (req.luck_value > ql) ? req.luck_value - ql : ql - req.luck_value;
	assign dh      = (req.hp_value > qh) ? req.hp_value - qh : qh - req.hp_value;

	always_comb begin
		sum_wide = {1'b0, partial_sum_q};
		if (slot_ok) begin
			sum_wide = {1'b0, partial_sum_q} + (DIST_W+1)'(dl) + (DIST_W+1)'(dh);
		end
		sum_sat = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
	end

	assign is_rec = req_fire && (req.opcode == OP_RECORD);
	assign is_fin = req_fire && (req.opcode == OP_FINISH);

	assign cmd_push     = (is_rec && req.end_of_record) || is_fin;
	assign cmd.kind     = is_fin ? CMD_FINISH : CMD_RECORD;
	assign cmd.rec_dist = sum_sat;
	assign cmd.label    = req.record_label;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_sum_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				query_luck_q[i] <= '0;
				query_hp_q[i]   <= '0;
			end
		end else begin
			if (req_fire && (req.opcode == OP_QUERY) && slot_ok) begin
				query_luck_q[qidx] <= req.luck_value;
				query_hp_q[qidx]   <= req.hp_value;
			end
			if (is_fin || (is_rec && req.end_of_record)) begin
				partial_sum_q <= '0;
			end else if (is_rec) begin
				partial_sum_q <= sum_sat;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/knr_cmdq.sv
// short command queue between front and back
`default_nettype none
module knr_cmdq
	import knr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_data,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output logic      nonempty,
	output logic      is_full
);

	cmd_t                mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CQ_CNT_W-1:0] count_q;

	assign rd_data  = mem_q[rd_ptr_q];
	assign nonempty = count_q != '0;
	assign is_full  = count_q == CQ_CNT_W'(CQ_DEPTH);

	function automatic logic [CQ_PTR_W-1:0] ptr_inc(input logic [CQ_PTR_W-1:0] p);
		ptr_inc = (p == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// File: sv/knr_back.sv
// back part: sorted insertion chain, best-record tracking, finish drain and result register
`default_nettype none
module knr_back
	import knr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      res_valid,
	output res_t      res,
	input  wire logic res_take
);

	back_st_t st_q, st_d;

	logic [DIST_W-1:0]  kd_q [KEEP];
	logic [LABEL_W-1:0] kl_q [KEEP];
	logic [CNT_W-1:0]   kept_count_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic [RNUM_W-1:0]  best_rec_q;
	logic               best_seen_q;
	logic [RNUM_W-1:0]  rec_cnt_q;

	logic               out_valid_q;
	res_t               out_q;

	logic               out_free;
	logic               is_full_list;
	logic [CNT_W-1:0]   end_idx;
	logic               ins_ok;
	logic [KEEP-1:0]    le;
	logic               do_record, do_drain, do_report;
	res_t               out_next;

	assign out_free     = !out_valid_q || res_take;
	assign is_full_list = kept_count_q == CNT_W'(KEEP);
	assign end_idx      = is_full_list ? CNT_W'(KEEP - 1) : kept_count_q;
	assign ins_ok       = !(is_full_list && (cmd.rec_dist >= kd_q[KEEP-1]));

	// entries that stay in place: valid and not farther than the newcomer
	always_comb begin
		for (int i = 0; i < KEEP; i++) begin
			le[i] = (CNT_W'(i) < end_idx) && (kd_q[i] <= cmd.rec_dist);
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_RUN: begin
				if (cmd_valid && (cmd.kind == CMD_FINISH)) begin
					st_d = (kept_count_q == '0) ? ST_REPORT : ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_free && (kept_count_q == CNT_W'(1))) begin
					st_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					st_d = ST_RUN;
				end
			end
			default: st_d = ST_RUN;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_pop   = 1'b0;
		do_record = 1'b0;
		do_drain  = 1'b0;
		do_report = 1'b0;
		out_next  = '0;
		case (st_q)
			ST_RUN: begin
				cmd_pop   = cmd_valid;
				do_record = cmd_valid && (cmd.kind == CMD_RECORD);
			end
			ST_DRAIN: begin
				do_drain           = out_free;
				out_next.item_kind = KIND_ENTRY;
				out_next.label_out = kl_q[0];
				out_next.distance  = kd_q[0];
			end
			ST_REPORT: begin
				do_report              = out_free;
				out_next.item_kind     = KIND_REPORT;
				out_next.distance      = best_seen_q ? best_dist_q : '0;
				out_next.record_number = best_seen_q ? best_rec_q : '0;
				out_next.found         = best_seen_q;
				out_next.last          = 1'b1;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_RUN;
			kept_count_q <= '0;
			best_dist_q  <= DIST_MAX;
			best_rec_q   <= '0;
			best_seen_q  <= 1'b0;
			rec_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (do_record) begin
				if (!is_full_list) begin
					kept_count_q <= kept_count_q + 1'b1;
				end
				if (!best_seen_q || (cmd.rec_dist < best_dist_q)) begin
					best_dist_q <= cmd.rec_dist;
					best_rec_q  <= rec_cnt_q;
					best_seen_q <= 1'b1;
				end
				if (rec_cnt_q != COUNT_MAX) begin
					rec_cnt_q <= rec_cnt_q + 1'b1;
				end
			end
			if (do_drain) begin
				kept_count_q <= kept_count_q - 1'b1;
			end
			if (do_report) begin
				kept_count_q <= '0;
				best_dist_q  <= DIST_MAX;
				best_rec_q   <= '0;
				best_seen_q  <= 1'b0;
				rec_cnt_q    <= '0;
			end
			if (do_drain || do_report) begin
				out_valid_q <= 1'b1;
			end else if (res_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// kept list and result payload
	always_ff @(posedge clk) begin
		if (do_record && ins_ok) begin
			for (int i = 0; i < KEEP; i++) begin
				if (!le[i]) begin
					if ((i == 0) || le[(i == 0) ? 0 : i - 1]) begin
						kd_q[i] <= cmd.rec_dist;
						kl_q[i] <= cmd.label;
					end else begin
						kd_q[i] <= kd_q[(i == 0) ? 0 : i - 1];
						kl_q[i] <= kl_q[(i == 0) ? 0 : i - 1];
					end
				end
			end
		end else if (do_drain) begin
			for (int i = 0; i < KEEP - 1; i++) begin
				kd_q[i] <= kd_q[i + 1];
				kl_q[i] <= kl_q[i + 1];
			end
		end
		if (do_drain || do_report) begin
			out_q <= out_next;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q <= CNT_W'(KEEP))
		else $error("kept count beyond store size");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DRAIN) |-> (kept_count_q != '0))
		else $error("draining an empty kept list");

	a_last_is_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.last == out_q.item_kind))
		else $error("last flag not on the report");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		(kept_count_q > CNT_W'(1)) |-> (kd_q[0] <= kd_q[1]))
		else $error("kept list out of order");

endmodule
`default_nettype wire

// File: tb/knr_result_monitor.sv
// result monitor of the nearest-records selector: predicts each result and checks it
module knr_result_monitor
	import knr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic full,
	input  wire req_t req,
	input  wire logic empty,
	input  wire logic pop,
	input  wire res_t res,
	output int        mismatches,
	output int        outstanding
);

	// own copy of the query and of the per-query run
	logic [VAL_W-1:0]   q_luck [SLOTS];
	logic [VAL_W-1:0]   q_hp [SLOTS];
	logic [DIST_W-1:0]  run_sum;
	logic [DIST_W-1:0]  near_dist [KEEP];
	logic [LABEL_W-1:0] near_label [KEEP];
	int                 near_count;
	logic [DIST_W-1:0]  best_dist;
	logic [RNUM_W-1:0]  best_idx;
	logic               best_valid;
	logic [RNUM_W-1:0]  rec_count;

	res_t due_results [$];

	function automatic int gap(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	task automatic clear_run();
		run_sum    = '0;
		near_count = 0;
		best_dist  = DIST_MAX;
		best_idx   = '0;
		best_valid = 1'b0;
		rec_count  = '0;
	endtask

	task automatic clear_all();
		for (int s = 0; s < SLOTS; s++) begin
			q_luck[s] = '0;
			q_hp[s]   = '0;
		end
		clear_run();
	endtask

	// sorted insertion, equal distances stay in arrival order
	task automatic file_neighbour(input logic [DIST_W-1:0] d, input logic [LABEL_W-1:0] l);
		int pos;
		int stop;
		if (near_count >= KEEP) begin
			if (d >= near_dist[KEEP-1])
				return;
			stop = KEEP - 1;
		end else begin
			stop = near_count;
			near_count++;
		end
		pos = 0;
		while (pos < stop && near_dist[pos] <= d)
			pos++;
		for (int i = stop; i > pos; i--) begin
			near_dist[i]  = near_dist[i-1];
			near_label[i] = near_label[i-1];
		end
		near_dist[pos]  = d;
		near_label[pos] = l;
	endtask

	task automatic apply_request(input req_t r);
		int   s;
		res_t e;
		case (r.opcode)
			OP_QUERY: begin
				if (r.slot_index < SLOTS) begin
					q_luck[r.slot_index] = r.luck_value;
					q_hp[r.slot_index]   = r.hp_value;
				end
			end
			OP_RECORD: begin
				if (r.slot_index < SLOTS) begin
					s = run_sum + gap(r.luck_value, q_luck[r.slot_index])
						+ gap(r.hp_value, q_hp[r.slot_index]);
					run_sum = (s > int'(DIST_MAX)) ? DIST_MAX : DIST_W'(s);
				end
				if (r.end_of_record) begin
					file_neighbour(run_sum, r.record_label);
					if (!best_valid || run_sum < best_dist) begin
						best_dist  = run_sum;
						best_idx   = rec_count;
						best_valid = 1'b1;
					end
					if (rec_count != COUNT_MAX)
						rec_count++;
					run_sum = '0;
				end
			end
			OP_FINISH: begin
				for (int i = 0; i < near_count; i++) begin
					e           = '0;
					e.item_kind = KIND_ENTRY;
					e.label_out = near_label[i];
					e.distance  = near_dist[i];
					due_results.push_back(e);
				end
				e               = '0;
				e.item_kind     = KIND_REPORT;
				e.distance      = best_valid ? best_dist : '0;
				e.record_number = best_valid ? best_idx : '0;
				e.found         = best_valid;
				e.last          = 1'b1;
				due_results.push_back(e);
				clear_run();
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		mismatches  = 0;
		outstanding = 0;
		clear_all();
	end

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			clear_all();
			due_results.delete();
		end else begin
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					$error("result with nothing due: %p", res);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("item_kind", want.item_kind, res.item_kind);
					check_field("label_out", want.label_out, res.label_out);
					check_field("distance", want.distance, res.distance);
					check_field("record_number", want.record_number, res.record_number);
					check_field("found", want.found, res.found);
					check_field("last", want.last, res.last);
				end
			end
			if (push && !full)
				apply_request(req);
		end
		outstanding = due_results.size();
	end

endmodule

// File: tb/tb_l1_nearest_records_top_k_core.sv
// testbench top of the nearest-records selector: stimulus, idling and verdict
module tb_l1_nearest_records_top_k_core;
	import knr_pkg::*;

	// opcode the block has no use for, it must swallow it silently
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic push   = 1'b0;
	logic pop    = 1'b0;
	req_t req    = '0;
	logic full;
	logic empty;
	res_t res;

	int   mismatches;
	int   outstanding;
	int   sent = 0;
	// both sides stop idling while this is high
	logic no_idle = 1'b0;

	l1_nearest_records_top_k_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

	knr_result_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req         (req),
		.empty       (empty),
		.pop         (pop),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiving side stalls with a chance of about one in six, never inside the quiet window
	always @(negedge clk) begin
		pop <= no_idle || ($urandom_range(0, 99) >= 17);
	end

	// one request: random gaps first (junk on the bus while push is low),
	// then hold it until an edge sees full low
	task automatic send(input logic [1:0] op, input int slot,
		input int luck, input int hp, input int label,
		input int eor);
		req_t r;
		r = '{opcode: op, slot_index: 3'(slot), luck_value: 8'(luck), hp_value: 8'(hp),
			record_label: 4'(label), end_of_record: 1'(eor)};
		while (!no_idle && $urandom_range(0, 99) < 17) begin
			push <= 1'b0;
			req  <= req_t'($urandom);
			@(negedge clk);
		end
		push <= 1'b1;
		req  <= r;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// sender holds off until every due result has come out
	task automatic settle();
		push <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	// a finish request with junk in every other field
	task automatic finish_run();
		send(OP_FINISH, $urandom_range(0, 7), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 1));
	endtask

	initial begin
		int goal;
		int episode;
		int n_rec;
		int len;
		bit tight;
		bit wild;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		// finish straight after reset: report only, nothing found
		finish_run();
		// query at the extremes; loads into slots six and seven are dropped
		send(OP_QUERY, 0, 8'd0, 8'd255, 4'd0, 1'b0);
		send(OP_QUERY, 1, 8'd255, 8'd0, 4'd15, 1'b1);
		send(OP_QUERY, 2, 8'd0, 8'd0, 4'd5, 1'b0);
		send(OP_QUERY, 3, 8'd255, 8'd255, 4'd10, 1'b1);
		send(OP_QUERY, 4, 8'd1, 8'd128, 4'd3, 1'b0);
		send(OP_QUERY, 5, 8'd128, 8'd1, 4'd12, 1'b0);
		send(OP_QUERY, 6, 8'd77, 8'd99, 4'd9, 1'b1);
		send(OP_QUERY, 7, 8'd200, 8'd33, 4'd6, 1'b0);
		// unknown opcode, no effect
		send(OP_UNUSED, 3, 8'd17, 8'd230, 4'd8, 1'b1);
		// record at the widest gap of slot zero, closed on an out-of-range slot
		send(OP_RECORD, 0, 8'd255, 8'd0, 4'd1, 1'b0);
		send(OP_RECORD, 7, 8'd255, 8'd255, 4'd2, 1'b0);
		send(OP_RECORD, 6, 8'd0, 8'd0, 4'd15, 1'b1);
		// exact match on slot three, distance zero
		send(OP_RECORD, 3, 8'd255, 8'd255, 4'd0, 1'b1);
		// long record, the running sum saturates
		for (int k = 0; k < 9; k++)
			send(OP_RECORD, 1, 8'd0, 8'd255, 4'd7, k == 8);
		// unfinished record, dropped by the finish
		send(OP_RECORD, 2, 8'd90, 8'd40, 4'd4, 1'b0);
		finish_run();
		settle();

		// random part: mostly well-formed query runs, some noise and broken records,
		// until the whole run has sent its share of requests
		goal    = 430;
		episode = 0;
		while (sent < goal) begin
			no_idle <= (episode >= 4 && episode < 8);
			if ($urandom_range(0, 9) < 6) begin
				for (int s = 0; s < SLOTS; s++)
					send(OP_QUERY, s, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 15), $urandom_range(0, 1));
				if ($urandom_range(0, 4) == 0)
					send(OP_QUERY, $urandom_range(SLOTS, 7), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 1));
			end
			// small values make equal distances common
			tight = $urandom_range(0, 1);
			n_rec = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 20);
			for (int r = 0; r < n_rec && sent < goal; r++) begin
				if ($urandom_range(0, 19) == 0)
					send(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 1));
				// some records repeat or skip slots, or run past the query length
				wild = ($urandom_range(0, 4) == 0);
				len  = wild ? $urandom_range(1, 10) : $urandom_range(1, SLOTS);
				for (int e = 0; e < len; e++)
					send(OP_RECORD, wild ? $urandom_range(0, 7) : e,
						tight ? $urandom_range(0, 3) : $urandom_range(0, 255),
						tight ? $urandom_range(0, 3) : $urandom_range(0, 255),
						$urandom_range(0, 15), e == len - 1);
			end
			// broken record left open at the finish
			if ($urandom_range(0, 5) == 0)
				for (int e = 0; e < 2; e++)
					send(OP_RECORD, $urandom_range(0, 7), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 15), 1'b0);
			finish_run();
			episode++;
		end
		no_idle <= 1'b0;

		// drain, then wait quietly to catch stray results
		settle();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
